@@ rtl/core/fvn_pkg.sv @@
// Package for the fractal value noise block: octave count, coordinate format
// and hash constants. No dependencies.
`timescale 1ns / 1ps

package fvn_pkg;

  localparam int unsigned OCTAVES       = 5;
  localparam int unsigned FRACTION_BITS = 16;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S   = 32'd1442695041;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam logic [31:0] SEED_STEP    = 32'd1013;

  // 3.0 in Q2.16 for the smoothstep polynomial.
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;
  // 1.0 in Q1.16 for the blend weights.
  localparam logic [16:0] BLEND_ONE    = 17'd65536;

endpackage

@@ rtl/core/fractal_value_noise_2d.sv @@
// Top level of the fractal value noise block: a nine-stage pipeline that
// evaluates all octaves in parallel lanes. Depends on fvn_pkg.
`timescale 1ns / 1ps

// Usage:
//   A request is taken at a rising edge where start_i is high and busy_o is
//   low. busy_o is always low: every octave has its own lane of pipeline
//   registers, so a new point may be presented in every cycle.
//   Each request gives exactly one result, noise_value_o, shown for one cycle
//   with done_o high. Throughput is one point per clock. The result is
//   registered through the stage chain: split, hash multiplies, hash mix,
//   final hash multiply, x blend, z blend, octave sum, reciprocal multiply,
//   quotient correction.
//   The receiver cannot stall the block; results are never held.
//   Reset (rst_ni low) clears the valid bits of all stages, so no result
//   appears for requests in flight at reset. The block keeps no other state.
module fractal_value_noise_2d
  import fvn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_z_i,
  input  logic        [31:0] noise_seed_i,
  output logic               done_o,
  output logic        [15:0] noise_value_o
);

  localparam int unsigned NSTAGE = 9;
  localparam int unsigned FB     = FRACTION_BITS;
  localparam int unsigned AW     = 24 + OCTAVES;
  localparam int unsigned QW     = 16 + OCTAVES;
  localparam int unsigned DW     = OCTAVES;
  localparam int unsigned RS     = QW;
  localparam longint unsigned DIV_VAL   = (64'd1 << OCTAVES) - 64'd1;
  localparam longint unsigned RECIP_VAL = (64'd1 << RS) / DIV_VAL;
  localparam logic [DW-1:0]   DIV   = DW'(DIV_VAL);
  localparam logic [RS:0]     RECIP = (RS+1)'(RECIP_VAL);

  typedef logic [23:0] corner_t;

  logic [NSTAGE:1] vld_q;

  // Stage registers, one lane per octave.
  logic [31:0] x0_q  [OCTAVES];
  logic [31:0] z0_q  [OCTAVES];
  logic [31:0] sd_q  [OCTAVES];
  logic [15:0] tx1_q [OCTAVES];
  logic [15:0] tz1_q [OCTAVES];

  logic [31:0] mx_q  [OCTAVES];
  logic [31:0] mz_q  [OCTAVES];
  logic [31:0] ms_q  [OCTAVES];
  logic [15:0] tx2_q [OCTAVES];
  logic [15:0] tz2_q [OCTAVES];
  logic [31:0] ttx_q [OCTAVES];
  logic [31:0] ttz_q [OCTAVES];

  logic [31:0] hp_q  [OCTAVES][4];
  logic [15:0] sx3_q [OCTAVES];
  logic [15:0] sz3_q [OCTAVES];

  logic [31:0] hm_q  [OCTAVES][4];
  logic [15:0] sx4_q [OCTAVES];
  logic [15:0] sz4_q [OCTAVES];

  corner_t     ab_q  [OCTAVES];
  corner_t     cd_q  [OCTAVES];
  logic [15:0] sz5_q [OCTAVES];

  corner_t     n_q   [OCTAVES];

  logic [AW-1:0] acc_q;
  logic [QW-1:0] q_q;
  logic [QW-1:0] apx_q;
  logic [15:0]   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTAGE-1:1], start_i};
    end
  end

  for (genvar k = 0; k < OCTAVES; k++) begin : g_lane
    logic [63:0] vx, vz;
    logic [15:0] tx_d, tz_d;
    logic [31:0] h_d [4];
    logic [31:0] hm_d [4];
    logic [49:0] px, pz;
    corner_t     cn [4];
    logic [16:0] wx, wz;
    logic [41:0] sab, scd, sn;

    assign vx = {{32{coord_x_i[31]}}, coord_x_i} << k;
    assign vz = {{32{coord_z_i[31]}}, coord_z_i} << k;

    if (FB >= 16) begin : g_frac_dn
      assign tx_d = vx[FB-1 -: 16];
      assign tz_d = vz[FB-1 -: 16];
    end else begin : g_frac_up
      assign tx_d = {vx[FB-1:0], {(16-FB){1'b0}}};
      assign tz_d = {vz[FB-1:0], {(16-FB){1'b0}}};
    end

    // Stage 1: cell index, fraction and octave seed.
    always_ff @(posedge clk_i) begin
      x0_q[k]  <= vx[FB+31:FB];
      z0_q[k]  <= vz[FB+31:FB];
      sd_q[k]  <= noise_seed_i + 32'(SEED_STEP * 32'(k));
      tx1_q[k] <= tx_d;
      tz1_q[k] <= tz_d;
    end

    // Stage 2: hash products of the base corner and squared fractions.
    always_ff @(posedge clk_i) begin
      mx_q[k]  <= x0_q[k] * HASH_MUL_X;
      mz_q[k]  <= z0_q[k] * HASH_MUL_Z;
      ms_q[k]  <= sd_q[k] * HASH_MUL_S;
      ttx_q[k] <= tx1_q[k] * tx1_q[k];
      ttz_q[k] <= tz1_q[k] * tz1_q[k];
      tx2_q[k] <= tx1_q[k];
      tz2_q[k] <= tz1_q[k];
    end

    // The neighbor corners add the multiplier itself, since (x+1)*C = x*C + C.
    always_comb begin
      h_d[0] = mx_q[k] ^ mz_q[k] ^ ms_q[k];
      h_d[1] = (mx_q[k] + HASH_MUL_X) ^ mz_q[k] ^ ms_q[k];
      h_d[2] = mx_q[k] ^ (mz_q[k] + HASH_MUL_Z) ^ ms_q[k];
      h_d[3] = (mx_q[k] + HASH_MUL_X) ^ (mz_q[k] + HASH_MUL_Z) ^ ms_q[k];
    end

    assign px = 50'(ttx_q[k]) * 50'(SMOOTH_THREE - {1'b0, tx2_q[k], 1'b0});
    assign pz = 50'(ttz_q[k]) * 50'(SMOOTH_THREE - {1'b0, tz2_q[k], 1'b0});

    // Stage 3: first hash mix and smoothstep weights.
    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 4; c++) begin
        hp_q[k][c] <= h_d[c] ^ (h_d[c] >> 13);
      end
      sx3_q[k] <= px[47:32];
      sz3_q[k] <= pz[47:32];
    end

    // Stage 4: final hash multiply.
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        hm_d[c] = hp_q[k][c] * HASH_MUL_MIX;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 4; c++) begin
        hm_q[k][c] <= hm_d[c];
      end
      sx4_q[k] <= sx3_q[k];
      sz4_q[k] <= sz3_q[k];
    end

    // Stage 5: corner values and blend along x.
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        cn[c] = hm_q[k][c][23:0] ^ {8'd0, hm_q[k][c][31:16]};
      end
    end

    assign wx  = BLEND_ONE - {1'b0, sx4_q[k]};
    assign sab = 42'(cn[0]) * 42'(wx) + 42'(cn[1]) * 42'({1'b0, sx4_q[k]});
    assign scd = 42'(cn[2]) * 42'(wx) + 42'(cn[3]) * 42'({1'b0, sx4_q[k]});

    always_ff @(posedge clk_i) begin
      ab_q[k]  <= sab[39:16];
      cd_q[k]  <= scd[39:16];
      sz5_q[k] <= sz4_q[k];
    end

    // Stage 6: blend along z.
    assign wz = BLEND_ONE - {1'b0, sz5_q[k]};
    assign sn = 42'(ab_q[k]) * 42'(wz) + 42'(cd_q[k]) * 42'({1'b0, sz5_q[k]});

    always_ff @(posedge clk_i) begin
      n_q[k] <= sn[39:16];
    end
  end

  // Stage 7: weighted octave sum; octave k carries weight 2^(OCTAVES-1-k).
  logic [AW-1:0] acc_d;
  always_comb begin
    acc_d = '0;
    for (int k = 0; k < OCTAVES; k++) begin
      acc_d = acc_d + (AW'(n_q[k]) << (OCTAVES - 1 - k));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Stage 8: divide by 2^8 with a shift, then estimate the quotient by the
  // odd divisor with a reciprocal multiply. The estimate is low by at most one.
  logic [QW-1:0]    q_d;
  logic [QW+RS:0]   prod;
  assign q_d  = acc_q[AW-1:8];
  assign prod = (QW+RS+1)'(q_d) * (QW+RS+1)'(RECIP);

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    apx_q <= prod[QW+RS-1:RS];
  end

  // Stage 9: one correction step on the remainder.
  logic [QW+DW:0] back, rem;
  logic [QW-1:0]  quo;
  assign back = (QW+DW+1)'(apx_q) * (QW+DW+1)'(DIV);
  assign rem  = (QW+DW+1)'(q_q) - back;
  assign quo  = (rem >= (QW+DW+1)'(DIV)) ? apx_q + QW'(1) : apx_q;

  always_ff @(posedge clk_i) begin
    res_q <= quo[15:0];
  end

  assign busy_o        = 1'b0;
  assign done_o        = vld_q[NSTAGE];
  assign noise_value_o = res_q;

  // A result only ever comes from a request that has passed through every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, NSTAGE))
    else $error("result without a matching request");

  // The reciprocal estimate must be within one of the true quotient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> rem < (QW+DW+1)'(2 * DIV_VAL))
    else $error("quotient estimate off by more than one");

  // The normalized sum must always fit the output width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (quo >> 16) == '0)
    else $error("normalized noise exceeds sixteen bits");

endmodule

@@ sim/fractal_value_noise_2d_tb.sv @@
// Testbench for fractal_value_noise_2d: drives random and directed points and
// checks every noise value against a local fixed-point predictor. Needs fvn_pkg.
`timescale 1ns / 1ps

class noise_scoreboard;
  logic [15:0] pending_noise[$];
  int unsigned mismatch_count;

  static function logic [23:0] corner_hash(logic [31:0] cx, logic [31:0] cz,
                                           logic [31:0] sd);
    logic [31:0] h;
    h = cx * fvn_pkg::HASH_MUL_X;
    h ^= cz * fvn_pkg::HASH_MUL_Z;
    h ^= sd * fvn_pkg::HASH_MUL_S;
    h = (h ^ (h >> 13)) * fvn_pkg::HASH_MUL_MIX;
    h ^= h >> 16;
    return h[23:0];
  endfunction

  static function logic [63:0] lerp24(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  // Splits one scaled coordinate into its wrapped cell index and smoothstep weight.
  static function void split_axis(logic signed [31:0] coord, int k,
                                  output logic [31:0] cell_idx, output logic [63:0] wt);
    logic [63:0] v;
    logic [63:0] t;
    v = 64'(coord) << k;
    cell_idx = v[47:16];
    t = {48'd0, v[15:0]};
    wt = (t * t * (64'd196608 - 2 * t)) >> 32;
  endfunction

  static function logic [15:0] fractal_noise(logic signed [31:0] x, logic signed [31:0] z,
                                             logic [31:0] seed);
    logic [63:0] acc;
    logic [63:0] fx, fz, ab, cd;
    logic [31:0] x0, z0, sd;
    acc = 0;
    for (int k = 0; k < fvn_pkg::OCTAVES; k++) begin
      sd = seed + fvn_pkg::SEED_STEP * k;
      split_axis(x, k, x0, fx);
      split_axis(z, k, z0, fz);
      ab = lerp24(corner_hash(x0, z0, sd), corner_hash(x0 + 1, z0, sd), fx);
      cd = lerp24(corner_hash(x0, z0 + 1, sd), corner_hash(x0 + 1, z0 + 1, sd), fx);
      acc += lerp24(ab, cd, fz) << (fvn_pkg::OCTAVES - 1 - k);
    end
    acc = acc / (((64'd1 << fvn_pkg::OCTAVES) - 1) << 8);
    return acc[15:0];
  endfunction

  function void note_request(logic signed [31:0] x, logic signed [31:0] z, logic [31:0] seed);
    pending_noise = {pending_noise, fractal_noise(x, z, seed)};
  endfunction

  function void check_noise(logic [15:0] got);
    logic [15:0] want;
    if (pending_noise.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_noise.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("noise_value expected %h got %h", want, got);
    end
  endfunction
endclass

module fractal_value_noise_2d_tb;
  import fvn_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic [31:0] noise_seed_i = '0;
  logic done_o;
  logic [15:0] noise_value_o;

  noise_scoreboard noise_sb = new();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fractal_value_noise_2d DUT (.*);

  always @(posedge clk_i) begin
    if (rst_ni && done_o) noise_sb.check_noise(noise_value_o);
  end

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return {1'b1, 15'd0, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hffff_0000 : 0);
      default: return 32'($signed($urandom_range(0, 40'h8_0000))) - 32'h4_0000;
    endcase
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_point(logic [31:0] x, logic [31:0] z, logic [31:0] seed);
    int gap;
    start_i <= 1'b1;
    coord_x_i <= x;
    coord_z_i <= z;
    noise_seed_i <= seed;
    do @(posedge clk_i); while (busy_o);
    noise_sb.note_request(x, z, seed);
    gap = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] edge_vals[8] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                  32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++)
      send_point(edge_vals[i], edge_vals[7 - i], i[0] ? 32'hffff_ffff : 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'hffff_fc00);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'hffff_ffff, 32'h0, 32'h1234_5678);
    send_point(32'h07ff_ffff, 32'hf800_0000, 32'h0);
    for (int i = 0; i < 550; i++) begin
      // Runs of requests, with the usual random gaps, sweep neighboring points in one field.
      if ($urandom_range(0, 9) == 0) begin
        logic [31:0] bx, bz, bs;
        bx = random_coord();
        bz = random_coord();
        bs = $urandom;
        repeat (8) begin
          send_point(bx, bz, bs);
          bx += $urandom_range(0, 16'h4000);
        end
        i += 7;
      end else begin
        send_point(random_coord(), random_coord(), $urandom);
      end
    end
    start_i <= 1'b0;
    while (noise_sb.pending_noise.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (noise_sb.mismatch_count == 0) $display("fractal_value_noise_2d_tb OK");
    else $display("fractal_value_noise_2d_tb NOT OK");
    $finish;
  end

  initial begin
    #2ms;
    $display("fractal_value_noise_2d_tb NOT OK");
    $finish;
  end
endmodule
